>>> hw/rtl/md5_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and helper functions for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // kind of block being compressed, selects how message words are formed
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_PADLEN,
    BLK_LEN
  } blk_e;

  typedef struct packed {
    logic       en;
    logic [5:0] pos;
    logic [7:0] data;
  } wr_t;

  typedef struct packed {
    logic [3:0] idx;
    blk_e       mode;
    logic [5:0] pad_pos;
  } rd_t;

  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [5:0] LastStep  = 6'd63;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [3:0] LenWordLo = 4'd14;
  localparam logic [3:0] LenWordHi = 4'd15;
  localparam logic [1:0] LastWord  = 2'd3;
  localparam logic [7:0] PadByte   = 8'h80;

  localparam logic [31:0] InitVec [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] StepConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a given step
  function automatic logic [3:0] msg_index(logic [5:0] step);
    logic [3:0] lo;
    lo = step[3:0];
    case (step[5:4])
      2'd0:    return lo;
      2'd1:    return 4'(4'd5 * lo + 4'd1);
      2'd2:    return 4'(4'd3 * lo + 4'd5);
      default: return 4'(4'd7 * lo);
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/md5_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5 stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_byte,
                output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/md5_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_round
// Shared MD5 step unit: round function, add of prefetched sum, rotate, add.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic [5:0]  step_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] pre_i,
  output logic [31:0] b_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] dbl;
  logic [4:0]  amt;

  always_comb begin
    case (step_i[5:4])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (b_i & d_i) | (c_i & ~d_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
  end

  // pre_i already holds a + w[g] + k
  assign t   = f + pre_i;
  assign amt = RotAmount[{step_i[5:4], step_i[1:0]}];
  assign dbl = {t, t} << amt;
  assign b_o = b_i + dbl[63:32];

endmodule
`default_nettype wire

>>> hw/rtl/md5_wbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_wbuf
// Block buffer of sixteen words with byte writes; forms padded message words.
// ----------------------------------------------------------------------------
module md5_wbuf (
  input  logic               clk_i,
  input  md5_pkg::wr_t       wr_i,
  input  md5_pkg::rd_t       rd_i,
  input  logic [63:0]        bit_len_i,
  output logic [31:0]        word_o
);
  import md5_pkg::*;

  logic [31:0] mem_q [16];
  logic [31:0] raw;
  logic [31:0] padded;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.pos[5:2]][{wr_i.pos[1:0], 3'b000} +: 8] <= wr_i.data;
    end
  end

  assign raw = mem_q[rd_i.idx];

  // bytes at the pad position become 0x80, bytes past it become zero
  always_comb begin
    logic [5:0] k;
    padded = '0;
    for (int j = 0; j < 4; j++) begin
      k = {rd_i.idx, 2'(j)};
      if (k < rd_i.pad_pos) begin
        padded[8*j +: 8] = raw[8*j +: 8];
      end else if (k == rd_i.pad_pos) begin
        padded[8*j +: 8] = PadByte;
      end else begin
        padded[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (rd_i.mode)
      BLK_DATA:   word_o = raw;
      BLK_PAD:    word_o = padded;
      BLK_PADLEN: word_o = padded;
      BLK_LEN:    word_o = '0;
      default:    word_o = raw;
    endcase
    if (rd_i.mode == BLK_PADLEN || rd_i.mode == BLK_LEN) begin
      if (rd_i.idx == LenWordLo) begin
        word_o = bit_len_i[31:0];
      end else if (rd_i.idx == LenWordHi) begin
        word_o = bit_len_i[63:32];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/md5_message_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one shared step unit under a small sequencer.
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer. The byte that fills the 64-byte block holds
// the input off while the block is compressed: the working words are loaded,
// 64 MD5 steps run on the single step unit (one step per cycle), and the
// result is added into the chaining state. A transfer marked last runs one
// padding block, or two when 56 or more bytes of the block are used, then
// presents words a, b, c, d on the output one per transfer; the input is not
// ready until the last of them is taken. The chaining state then returns to
// the initial vector for the next message.
module md5_message_digest (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    byte_i,
  md5_out_if.source digest_o
);
  import md5_pkg::*;

  state_e      state_q, state_d;
  blk_e        mode_q, mode_d;
  logic        last_pend_q, last_pend_d;
  logic [5:0]  pos_q, pos_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  widx_q, widx_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  logic [31:0] pre_q, pre_d;

  logic        in_xfer;
  logic        out_xfer;
  logic [5:0]  pos_new;
  logic [5:0]  fetch_step;
  logic [31:0] msg_word;
  logic [31:0] new_b;
  wr_t         wr;
  rd_t         rd;

  assign byte_i.ready = (state_q == ST_IDLE);
  assign in_xfer      = byte_i.valid & byte_i.ready;
  assign out_xfer     = digest_o.valid & digest_o.ready;

  assign digest_o.valid       = (state_q == ST_OUT);
  assign digest_o.digest_word = chain_q[widx_q];
  assign digest_o.word_index  = widx_q;
  assign digest_o.last_word   = (widx_q == LastWord);

  // the word for the next step is fetched during the current one and registered
  assign fetch_step = (state_q == ST_ROUND) ? rnd_q + 6'd1 : 6'd0;

  assign wr.en   = in_xfer & byte_i.has_byte;
  assign wr.pos  = pos_q;
  assign wr.data = byte_i.data_byte;

  assign rd.idx     = msg_index(fetch_step);
  assign rd.mode    = mode_q;
  assign rd.pad_pos = pos_q;

  md5_wbuf u_wbuf (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .bit_len_i ({cnt_q, 3'b000}),
    .word_o    (msg_word)
  );

  md5_round u_round (
    .step_i (rnd_q),
    .b_i    (wb_q),
    .c_i    (wc_q),
    .d_i    (wd_q),
    .pre_i  (pre_q),
    .b_o    (new_b)
  );

  assign pos_new = 6'(pos_q + {5'b0, byte_i.has_byte});

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    last_pend_d = last_pend_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    widx_d      = widx_q;
    chain_d     = chain_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wc_d        = wc_q;
    wd_d        = wd_q;
    // next a is the current d, or the chaining a before the first step
    pre_d = ((state_q == ST_ROUND) ? wd_q : chain_q[0]) + msg_word + StepConst[fetch_step];

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pos_d = pos_new;
          if (byte_i.has_byte) begin
            cnt_d = cnt_q + 61'd1;
          end
          if (byte_i.has_byte && pos_q == LastPos) begin
            mode_d      = BLK_DATA;
            last_pend_d = byte_i.last_byte;
            state_d     = ST_LOAD;
          end else if (byte_i.last_byte) begin
            mode_d  = (pos_new >= LenPos) ? BLK_PAD : BLK_PADLEN;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        wa_d    = chain_q[0];
        wb_d    = chain_q[1];
        wc_d    = chain_q[2];
        wd_d    = chain_q[3];
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        wa_d  = wd_q;
        wd_d  = wc_q;
        wc_d  = wb_q;
        wb_d  = new_b;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastStep) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d[0] = chain_q[0] + wa_q;
        chain_d[1] = chain_q[1] + wb_q;
        chain_d[2] = chain_q[2] + wc_q;
        chain_d[3] = chain_q[3] + wd_q;
        case (mode_q)
          BLK_DATA: begin
            if (last_pend_q) begin
              last_pend_d = 1'b0;
              mode_d      = BLK_PADLEN;
              state_d     = ST_LOAD;
            end else begin
              state_d = ST_IDLE;
            end
          end
          BLK_PAD: begin
            mode_d  = BLK_LEN;
            state_d = ST_LOAD;
          end
          default: begin
            widx_d  = '0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_xfer) begin
          widx_d = widx_q + 2'd1;
          if (widx_q == LastWord) begin
            chain_d = InitVec;
            cnt_d   = '0;
            pos_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= BLK_DATA;
      last_pend_q <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      widx_q      <= '0;
      chain_q     <= InitVec;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      last_pend_q <= last_pend_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      widx_q      <= widx_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wc_q  <= wc_d;
    wd_q  <= wd_d;
    pre_q <= pre_d;
  end

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_o.valid |-> !byte_i.ready)
    else $error("input accepted while digest words pending");

  a_restart_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && digest_o.last_word) |=>
      (state_q == ST_IDLE && chain_q[0] == InitVec[0] && pos_q == '0 && cnt_q == '0))
    else $error("state not returned to initial vector after digest");

  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && mode_q == BLK_PADLEN) |-> (pos_q < LenPos))
    else $error("length field overlaps message bytes");

  a_pad_then_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD && mode_q == BLK_PAD) |=> (state_q == ST_LOAD && mode_q == BLK_LEN))
    else $error("padding block not followed by length block");

endmodule
`default_nettype wire
